>>> sv/hierarchical_voxel_occupancy_octree_assert.svh
// Assertion macros shared by the checker of the voxel occupancy octree.
// Depends on nothing; included by the checker file.
`ifndef HIERARCHICAL_VOXEL_OCCUPANCY_OCTREE_ASSERT_SVH
`define HIERARCHICAL_VOXEL_OCCUPANCY_OCTREE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVO_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hvo_pkg.sv
// Shared constants and types of the voxel occupancy octree.
// Depends on nothing; imported by every module of the block.
package hvo_pkg;

    localparam int unsigned TREE_DEPTH_DEF = 6;
    localparam int unsigned COORD_W        = 6;
    localparam int unsigned LEVELS_W       = 3;
    localparam int unsigned TRIPLE_SHIFT   = 3;
    localparam int unsigned QUEUE_DEPTH    = 2;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } hvo_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } hvo_back_state_t;

    typedef struct packed {
        logic clearing;
    } hvo_status_t;

endpackage

>>> sv/hierarchical_voxel_occupancy_octree.sv
// The walker takes one request at a time and updates 1 to TREE_DEPTH levels of node bytes,
// reported as levels_written, walking up from the leaf layer; each level goes through a read
// state and then a write state of the node memory.
// Up to two further requests wait in the queue; busy is high while it is full.
// Reset: asynchronous; afterwards a clearing pass zeroes all (8^TREE_DEPTH-1)/7 nodes (37449
// at the default depth) of the node memory with busy high. Results cannot be stalled.
module hierarchical_voxel_occupancy_octree
    import hvo_pkg::*;
#(
    parameter int unsigned TREE_DEPTH = TREE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [COORD_W-1:0]  voxel_x,
    input  logic [COORD_W-1:0]  voxel_y,
    input  logic [COORD_W-1:0]  voxel_z,
    output logic                done,
    output logic [7:0]          root_octants,
    output logic [LEVELS_W-1:0] levels_written
);

    localparam int unsigned ENTRY_W = 3 * TREE_DEPTH + 1;

    hvo_status_t        status;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] head_entry;

    hvo_front #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .op         (op),
        .voxel_x    (voxel_x),
        .voxel_y    (voxel_y),
        .voxel_z    (voxel_z),
        .status     (status),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    hvo_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head      (head_entry),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    hvo_back #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head_entry),
        .empty          (queue_empty),
        .pop            (pop),
        .status         (status),
        .done           (done),
        .root_octants   (root_octants),
        .levels_written (levels_written)
    );

endmodule

>>> sv/hvo_front.sv
// Front end: takes requests, forms the Morton code and pushes it to the queue.
// Depends on hvo_pkg.
module hvo_front
    import hvo_pkg::*;
#(
    parameter int unsigned TREE_DEPTH = TREE_DEPTH_DEF,
    localparam int unsigned CODE_W    = 3 * TREE_DEPTH,
    localparam int unsigned ENTRY_W   = CODE_W + 1
)
(
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [COORD_W-1:0] voxel_x,
    input  logic [COORD_W-1:0] voxel_y,
    input  logic [COORD_W-1:0] voxel_z,
    input  hvo_status_t        status,
    input  logic               queue_full,
    output logic               push,
    output logic [ENTRY_W-1:0] entry
);

    localparam int unsigned USED_BITS = (TREE_DEPTH < COORD_W) ? TREE_DEPTH : COORD_W;

    logic [CODE_W-1:0] code;

    // Coordinate bits above the tree depth are dropped; missing ones read as zero.
    always_comb
    begin
        code = '0;
        for (int i = 0; i < USED_BITS; i++)
        begin
            code[3*i]     = voxel_x[i];
            code[3*i + 1] = voxel_y[i];
            code[3*i + 2] = voxel_z[i];
        end
    end

    assign busy  = status.clearing | queue_full;
    assign push  = start & ~busy;
    assign entry = {op, code};

endmodule

>>> sv/hvo_queue.sv
// Short request queue between the front end and the tree walker.
// Depends on hvo_pkg.
module hvo_queue
    import hvo_pkg::*;
#(
    parameter int unsigned ENTRY_W = 19
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head,
    output logic               empty,
    output logic               full
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/hvo_back.sv
// Tree walker: node byte memory, clearing pass and the upward read-modify-write walk.
// Depends on hvo_pkg.
module hvo_back
    import hvo_pkg::*;
#(
    parameter int unsigned TREE_DEPTH = TREE_DEPTH_DEF,
    localparam int unsigned CODE_W    = 3 * TREE_DEPTH,
    localparam int unsigned ENTRY_W   = CODE_W + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ENTRY_W-1:0]  head,
    input  logic                empty,
    output logic                pop,
    output hvo_status_t         status,
    output logic                done,
    output logic [7:0]          root_octants,
    output logic [LEVELS_W-1:0] levels_written
);

    localparam int unsigned NODE_COUNT = ((1 << (3 * TREE_DEPTH)) - 1) / 7;
    localparam int unsigned LEAF_BASE  = ((1 << (3 * (TREE_DEPTH - 1))) - 1) / 7;
    localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
    localparam int unsigned LAYER_W    = $clog2(TREE_DEPTH);

    logic [7:0] mem [NODE_COUNT];

    hvo_back_state_t     state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   node_reg, node_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [2:0]          bit_reg, bit_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [LEVELS_W-1:0] count_reg, count_next;
    hvo_op_t             op_reg, op_next;
    logic                done_reg, done_next;
    logic [LEVELS_W-1:0] levels_reg, levels_next;
    logic [7:0]          root_reg, root_next;
    logic [7:0]          rd_data_reg;

    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic [7:0]          bit_mask;
    logic                stop;

    assign rd_addr  = base_reg + node_reg;
    assign bit_mask = 8'b1 << bit_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        node_next     = node_reg;
        base_next     = base_reg;
        addr_next     = addr_reg;
        bit_next      = bit_reg;
        layer_next    = layer_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        done_next     = 1'b0;
        levels_next   = levels_reg;
        root_next     = root_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = '0;
        stop          = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    op_next    = hvo_op_t'(head[ENTRY_W-1]);
                    bit_next   = head[2:0];
                    node_next  = ADDR_W'(head[CODE_W-1:TRIPLE_SHIFT]);
                    base_next  = ADDR_W'(LEAF_BASE);
                    layer_next = LAYER_W'(TREE_DEPTH - 1);
                    count_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                addr_next  = rd_addr;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en = 1'b1;
                if (op_reg == OP_REMOVE)
                begin
                    wr_data = rd_data_reg & ~bit_mask;
                    stop    = (wr_data != '0);
                end
                else
                begin
                    wr_data = rd_data_reg | bit_mask;
                    stop    = (rd_data_reg != '0);
                end
                count_next = count_reg + 1'b1;
                if (layer_reg == '0)
                begin
                    root_next = wr_data;
                end
                if (stop || layer_reg == '0)
                begin
                    done_next   = 1'b1;
                    levels_next = count_reg + 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // Step to the parent: next triple picks the bit, base moves up a layer.
                    bit_next   = node_reg[2:0];
                    node_next  = node_reg >> TRIPLE_SHIFT;
                    base_next  = (base_reg - 1'b1) >> TRIPLE_SHIFT;
                    layer_next = layer_reg - 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            root_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            root_reg     <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        base_reg   <= base_next;
        addr_reg   <= addr_next;
        bit_reg    <= bit_next;
        layer_reg  <= layer_next;
        count_reg  <= count_next;
        op_reg     <= op_next;
        levels_reg <= levels_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign done            = done_reg;
    assign root_octants    = root_reg;
    assign levels_written  = levels_reg;

endmodule

>>> sv/hvo_checker.sv
// Port-level checker for the voxel occupancy octree, bound to the top level.
// Depends on hvo_pkg and the assertion macro header.
`include "hierarchical_voxel_occupancy_octree_assert.svh"

module hvo_checker
    import hvo_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [LEVELS_W-1:0] levels_written
);

    localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 1;
    localparam int unsigned PEND_W      = $clog2(MAX_PENDING + 1);

    logic [PEND_W-1:0] pending_reg;
    logic              accept;

    assign accept = start & ~busy;

    // Requests accepted whose result has not yet been strobed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (accept && !done)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (done && !accept)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `HVO_ASSERT_IMPLY(a_done_has_request, clk, rst_n, done, pending_reg != '0,
        "result strobed with no request outstanding")
    `HVO_ASSERT_IMPLY(a_accept_bounded, clk, rst_n, accept,
        pending_reg != PEND_W'(MAX_PENDING), "request accepted beyond queue capacity")
    `HVO_ASSERT_IMPLY(a_levels_nonzero, clk, rst_n, done, levels_written != '0,
        "result reports zero levels written")
    `HVO_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done,
        "result strobe held for two cycles")

endmodule

bind hierarchical_voxel_occupancy_octree hvo_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .levels_written (levels_written)
);
